// ===== hw/rtl/hsba_pkg.sv =====
// Shared types and constants for the HSV saturation/brightness adjust unit.
// No dependencies.
package hsba_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned LVL_W         = 7;
  localparam int unsigned FRACTION_BITS = 16;

  localparam logic [LVL_W-1:0] LVL_NEUTRAL = 7'd50;
  localparam logic [LVL_W-1:0] LVL_RESET   = 7'd50;

  // ceil(2^20 / 50), exact for brightness products up to 77*255
  localparam logic [14:0] BRT_RECIP = 15'd20972;
  localparam int unsigned BRT_SHIFT = 20;

  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_SATURATION = 1'b1;

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } max_sel_e;

  typedef struct packed {
    logic [CH_W-1:0] mx;
    max_sel_e        sel;
    logic            neg;
    logic            delta_zero;
    logic            max_zero;
  } side_t;

endpackage

// ===== hw/rtl/hsba_div.sv =====
// Pipelined dual restoring divider: (n << F) / d for n <= d, one quotient bit per stage.
// Depends on hsba_pkg.
module hsba_div #(
  parameter int unsigned FRACTION_BITS = hsba_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  hsba_pkg::side_t                side_i,
  input  logic [hsba_pkg::CH_W-1:0]      hue_num_i,
  input  logic [hsba_pkg::CH_W-1:0]      hue_den_i,
  input  logic [hsba_pkg::CH_W-1:0]      sat_num_i,
  input  logic [hsba_pkg::CH_W-1:0]      sat_den_i,
  output logic                           valid_o,
  output hsba_pkg::side_t                side_o,
  output logic [FRACTION_BITS:0]         hue_quo_o,
  output logic [FRACTION_BITS:0]         sat_quo_o
);

  localparam int unsigned NST = FRACTION_BITS + 1;
  localparam int unsigned QW  = FRACTION_BITS + 1;
  localparam int unsigned CW  = hsba_pkg::CH_W;

  logic [NST-1:0]  vld_q;
  hsba_pkg::side_t side_q [NST];
  logic [CW-1:0]   hr_q [NST];
  logic [CW-1:0]   hd_q [NST];
  logic [CW-1:0]   sr_q [NST];
  logic [CW-1:0]   sd_q [NST];
  logic [QW-1:0]   hq_q [NST];
  logic [QW-1:0]   sq_q [NST];

  function automatic logic [CW:0] div_step(input logic [CW:0] r, input logic [CW-1:0] d);
    logic          b;
    logic [CW:0]   diff;
    b    = (r >= {1'b0, d});
    diff = r - {1'b0, d};
    return b ? {1'b1, diff[CW-1:0]} : {1'b0, r[CW-1:0]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [CW:0] hs;
    logic [CW:0] ss;
    hs = div_step({1'b0, hue_num_i}, hue_den_i);
    ss = div_step({1'b0, sat_num_i}, sat_den_i);
    side_q[0] <= side_i;
    hd_q[0]   <= hue_den_i;
    sd_q[0]   <= sat_den_i;
    hr_q[0]   <= hs[CW-1:0];
    sr_q[0]   <= ss[CW-1:0];
    hq_q[0]   <= {{(QW-1){1'b0}}, hs[CW]};
    sq_q[0]   <= {{(QW-1){1'b0}}, ss[CW]};
    for (int k = 1; k < NST; k++) begin
      hs = div_step({hr_q[k-1], 1'b0}, hd_q[k-1]);
      ss = div_step({sr_q[k-1], 1'b0}, sd_q[k-1]);
      side_q[k] <= side_q[k-1];
      hd_q[k]   <= hd_q[k-1];
      sd_q[k]   <= sd_q[k-1];
      hr_q[k]   <= hs[CW-1:0];
      sr_q[k]   <= ss[CW-1:0];
      hq_q[k]   <= {hq_q[k-1][QW-2:0], hs[CW]};
      sq_q[k]   <= {sq_q[k-1][QW-2:0], ss[CW]};
    end
  end

  assign valid_o   = vld_q[NST-1];
  assign side_o    = side_q[NST-1];
  assign hue_quo_o = hq_q[NST-1];
  assign sat_quo_o = sq_q[NST-1];

endmodule

// ===== hw/rtl/hsv_saturation_brightness_adjust_unit.sv =====
// Top level of the HSV saturation/brightness adjust unit.
// Depends on hsba_pkg and hsba_div.
//
// Usage:
//   A pixel (red_i, green_i, blue_i) is taken on a rising edge with start_i
//   high and busy_o low. busy_o is always low: a pixel may enter every cycle.
//   The adjusted pixel appears on red_o/green_o/blue_o with valid_o high for
//   exactly one cycle, and is taken at the edge that ends that cycle.
//   Throughput is one pixel per cycle.
//   The pipeline holds the two pipelined dividers (hue fraction and
//   saturation), one quotient bit per stage, FRACTION_BITS + 1 stages,
//   plus input clamp, min/max, hue/sat fixup, two multiplier stages and
//   the output register.
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 brightness, 1 saturation); the derived offset and saturation step are
//   computed at the write, so a pixel may follow on the next edge.
//   Reset clears all beat valid bits and sets both levels to 50.
//   The receiver cannot stall; each result beat is shown once.
module hsv_saturation_brightness_adjust_unit #(
  parameter int unsigned FRACTION_BITS = hsba_pkg::FRACTION_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [hsba_pkg::CH_W-1:0]     red_i,
  input  logic [hsba_pkg::CH_W-1:0]     green_i,
  input  logic [hsba_pkg::CH_W-1:0]     blue_i,
  output logic                          valid_o,
  output logic [hsba_pkg::CH_W-1:0]     red_o,
  output logic [hsba_pkg::CH_W-1:0]     green_o,
  output logic [hsba_pkg::CH_W-1:0]     blue_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hsba_pkg::LVL_W-1:0]    cfg_wdata_i
);

  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned CW  = hsba_pkg::CH_W;
  localparam int unsigned QW  = FB + 1;
  localparam int unsigned HW  = FB + 4;
  localparam int unsigned CPW = FB + 9;
  localparam int unsigned SPW = 2 * FB + 13;
  localparam int unsigned XPW = 2 * FB + 10;
  localparam int unsigned LAT = FB + 7;
  localparam longint unsigned SAT_RECIP_L = ((64'd1 << (FB + 12)) + 64'd49) / 64'd50;
  localparam logic [FB+6:0]   SAT_RECIP   = SAT_RECIP_L[FB+6:0];
  localparam logic [QW-1:0]   ONE         = {1'b1, {FB{1'b0}}};
  localparam logic signed [HW-1:0] H_ONE  = {{(HW-1){1'b0}}, 1'b1} << FB;

  // ---------------- configuration ----------------
  logic signed [9:0]    offset_q, offset_d;
  logic signed [FB+2:0] step_q, step_d;

  logic signed [7:0] lvl_s;
  logic [6:0]        lvl_a;
  logic [29:0]       brt_prod;
  logic [8:0]        brt_mag;
  logic              sat_hi;
  logic [5:0]        sat_rr;
  logic [SPW-1:0]    sat_prod;
  logic [QW-1:0]     sat_mag;

  always_comb begin
    lvl_s    = $signed({1'b0, cfg_wdata_i}) - $signed({1'b0, hsba_pkg::LVL_NEUTRAL});
    lvl_a    = lvl_s[7] ? 7'(-lvl_s) : lvl_s[6:0];
    brt_prod = 30'(30'(lvl_a) * 30'd255) * 30'(hsba_pkg::BRT_RECIP);
    brt_mag  = brt_prod[hsba_pkg::BRT_SHIFT+8:hsba_pkg::BRT_SHIFT];
    sat_hi   = (lvl_a >= 7'd50);
    sat_rr   = sat_hi ? 6'(lvl_a - 7'd50) : lvl_a[5:0];
    sat_prod = SPW'({sat_rr, {FB{1'b0}}}) * SPW'(SAT_RECIP);
    sat_mag  = {sat_hi, sat_prod[FB+12+FB-1:FB+12]};
    offset_d = offset_q;
    step_d   = step_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        hsba_pkg::REG_BRIGHTNESS: begin
          offset_d = lvl_s[7] ? -$signed({1'b0, brt_mag}) : $signed({1'b0, brt_mag});
        end
        hsba_pkg::REG_SATURATION: begin
          step_d = lvl_s[7] ? -$signed({2'b0, sat_mag}) : $signed({2'b0, sat_mag});
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      step_q   <= '0;
    end else begin
      offset_q <= offset_d;
      step_q   <= step_d;
    end
  end

  // ---------------- S0: brightness offset and clamp ----------------
  function automatic logic [CW-1:0] clamp_ch(input logic [CW-1:0] v, input logic signed [9:0] o);
    logic signed [10:0] s;
    s = $signed({3'b0, v}) + 11'(o);
    if (s < 0) return '0;
    if (s > 11'sd255) return 8'hFF;
    return s[CW-1:0];
  endfunction

  logic          accept;
  logic          v0_q, v1_q, v5_q, v6_q, v7_q, v8_q;
  logic [CW-1:0] r0_q, g0_q, b0_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    r0_q <= clamp_ch(red_i, offset_q);
    g0_q <= clamp_ch(green_i, offset_q);
    b0_q <= clamp_ch(blue_i, offset_q);
  end

  // ---------------- S1: max, min, hue numerator ----------------
  hsba_pkg::side_t side1_q;
  logic [CW-1:0]   hn1_q, hd1_q, sn1_q, sd1_q;

  logic [CW-1:0]     mx, mn;
  logic signed [8:0] diff;
  hsba_pkg::max_sel_e sel;

  always_comb begin
    mx = r0_q;
    mn = r0_q;
    if (g0_q > mx) mx = g0_q;
    if (b0_q > mx) mx = b0_q;
    if (g0_q < mn) mn = g0_q;
    if (b0_q < mn) mn = b0_q;
    if (r0_q == mx) begin
      sel  = hsba_pkg::SEL_RED;
      diff = $signed({1'b0, g0_q}) - $signed({1'b0, b0_q});
    end else if (g0_q == mx) begin
      sel  = hsba_pkg::SEL_GREEN;
      diff = $signed({1'b0, b0_q}) - $signed({1'b0, r0_q});
    end else begin
      sel  = hsba_pkg::SEL_BLUE;
      diff = $signed({1'b0, r0_q}) - $signed({1'b0, g0_q});
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q.mx         <= mx;
    side1_q.sel        <= sel;
    side1_q.neg        <= diff[8];
    side1_q.delta_zero <= (mx == mn);
    side1_q.max_zero   <= (mx == '0);
    hn1_q              <= diff[8] ? 8'(-diff) : diff[7:0];
    hd1_q              <= mx - mn;
    sn1_q              <= mx - mn;
    sd1_q              <= mx;
  end

  // ---------------- dividers ----------------
  logic            vd;
  hsba_pkg::side_t sided;
  logic [QW-1:0]   hq, sq;

  hsba_div #(.FRACTION_BITS(FB)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v1_q),
    .side_i    (side1_q),
    .hue_num_i (hn1_q),
    .hue_den_i (hd1_q),
    .sat_num_i (sn1_q),
    .sat_den_i (sd1_q),
    .valid_o   (vd),
    .side_o    (sided),
    .hue_quo_o (hq),
    .sat_quo_o (sq)
  );

  // ---------------- P1: hue wrap, saturation step and clamp ----------------
  logic [FB+2:0]  hue5_q;
  logic [QW-1:0]  sat5_q;
  logic [CW-1:0]  mx5_q;

  logic signed [HW-1:0] hue_raw, hbase, qx, sat_raw;
  logic [QW-1:0]        sat_c;

  always_comb begin
    qx = $signed({3'b0, hq});
    case (sided.sel)
      hsba_pkg::SEL_GREEN: hbase = H_ONE <<< 1;
      hsba_pkg::SEL_BLUE:  hbase = H_ONE <<< 2;
      default:             hbase = '0;
    endcase
    hue_raw = hbase + (sided.neg ? -qx : qx);
    if (sided.delta_zero) hue_raw = '0;
    if (hue_raw < 0) hue_raw = hue_raw + HW'(H_ONE * 6);
    sat_raw = (sided.max_zero ? '0 : $signed({3'b0, sq})) + HW'(step_q);
    if (sat_raw < 0) sat_c = '0;
    else if (sat_raw > $signed({3'b0, ONE})) sat_c = ONE;
    else sat_c = sat_raw[QW-1:0];
  end

  always_ff @(posedge clk_i) begin
    hue5_q <= hue_raw[FB+2:0];
    sat5_q <= sat_c;
    mx5_q  <= sided.mx;
  end

  // ---------------- P2: sector, triangle term, chroma ----------------
  logic [2:0]     sec6_q;
  logic [QW-1:0]  omt6_q;
  logic [CPW-1:0] c6_q;
  logic [CW-1:0]  mx6_q;

  logic [QW-1:0] hmod2, tri_t;

  always_comb begin
    hmod2 = {hue5_q[FB], hue5_q[FB-1:0]};
    tri_t = (hmod2 >= ONE) ? (hmod2 - ONE) : (ONE - hmod2);
  end

  always_ff @(posedge clk_i) begin
    sec6_q <= hue5_q[FB+2:FB];
    omt6_q <= ONE - tri_t;
    c6_q   <= CPW'(mx5_q) * CPW'(sat5_q);
    mx6_q  <= mx5_q;
  end

  // ---------------- P3: x and m ----------------
  logic [2:0]     sec7_q;
  logic [CPW-1:0] c7_q, x7_q, m7_q;
  logic [XPW-1:0] xprod;

  assign xprod = XPW'(c6_q) * XPW'(omt6_q);

  always_ff @(posedge clk_i) begin
    sec7_q <= sec6_q;
    c7_q   <= c6_q;
    x7_q   <= xprod[FB+CPW-1:FB];
    m7_q   <= CPW'({mx6_q, {FB{1'b0}}}) - c6_q;
  end

  // ---------------- P4: sector map and output ----------------
  logic [CPW-1:0] pr, pg, pb, sr, sg, sb;

  always_comb begin
    case (sec7_q)
      3'd0:    begin pr = c7_q; pg = x7_q; pb = '0;   end
      3'd1:    begin pr = x7_q; pg = c7_q; pb = '0;   end
      3'd2:    begin pr = '0;   pg = c7_q; pb = x7_q; end
      3'd3:    begin pr = '0;   pg = x7_q; pb = c7_q; end
      3'd4:    begin pr = x7_q; pg = '0;   pb = c7_q; end
      default: begin pr = c7_q; pg = '0;   pb = x7_q; end
    endcase
    sr = pr + m7_q;
    sg = pg + m7_q;
    sb = pb + m7_q;
  end

  always_ff @(posedge clk_i) begin
    red_o   <= sr[FB+7:FB];
    green_o <= sg[FB+7:FB];
    blue_o  <= sb[FB+7:FB];
  end

  // ---------------- beat valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v5_q <= vd;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  assign valid_o = v8_q;

  // ---------------- assertions ----------------
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("accepted beat did not emerge after pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(accept, LAT) |-> !valid_o)
    else $error("result beat without matching input beat");

  a_gray_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && sec6_q > 3'd5) |-> 1'b0)
    else $error("hue sector out of range");

endmodule
